// ===== rtl/dmsd_pkg.sv =====
// Door magnet state detector: shared types and constants.
// Used by the core and the testbench files; depends on nothing.
package dmsd_pkg;

  localparam int AXES       = 3;
  localparam int CFG_W      = 16;
  localparam int CFG_ADDR_W = 2;
  localparam int CODE_W     = 3;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_OPEN_THR  = 2'd0,
    REG_CLOSE_THR = 2'd1,
    REG_DELTA_THR = 2'd2
  } cfg_reg_t;

  localparam logic [CFG_W-1:0] OPEN_THR_RST  = 16'd200;
  localparam logic [CFG_W-1:0] CLOSE_THR_RST = 16'd400;
  localparam logic [CFG_W-1:0] DELTA_THR_RST = 16'd10;

  typedef enum logic [4:0] {
    DOOR_UNKNOWN = 5'b00001,
    DOOR_OPEN    = 5'b00010,
    DOOR_CLOSING = 5'b00100,
    DOOR_CLOSED  = 5'b01000,
    DOOR_OPENING = 5'b10000
  } door_state_t;

  localparam logic [CODE_W-1:0] CODE_UNKNOWN = 3'd0;
  localparam logic [CODE_W-1:0] CODE_OPEN    = 3'd1;
  localparam logic [CODE_W-1:0] CODE_CLOSING = 3'd2;
  localparam logic [CODE_W-1:0] CODE_CLOSED  = 3'd3;
  localparam logic [CODE_W-1:0] CODE_OPENING = 3'd4;

endpackage

// ===== rtl/dmsd_tap.sv =====
// One cell of the moving-average history line: holds one sample.
// Depends on nothing; chained by dmsd_axis.
module dmsd_tap #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          shift_en,
  input  logic signed [SAMPLE_BITS-1:0] d,
  output logic signed [SAMPLE_BITS-1:0] q
);

  logic signed [SAMPLE_BITS-1:0] q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r <= '0;
    end else if (shift_en) begin
      q_r <= d;
    end
  end

  assign q = q_r;

endmodule

// ===== rtl/dmsd_axis.sv =====
// Moving-average front end of one axis: a line of WINDOW history cells
// and a running sum. Depends on dmsd_tap.
module dmsd_axis #(
  parameter int WINDOW      = 8,
  parameter int SAMPLE_BITS = 16,
  localparam int SUM_W      = SAMPLE_BITS + $clog2(WINDOW)
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          feed,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  output logic signed [SUM_W-1:0]       sum
);

  logic signed [SAMPLE_BITS-1:0] tap_w [WINDOW+1];
  logic signed [SUM_W-1:0]       sum_r;
  logic signed [SUM_W-1:0]       sum_nxt;

  assign tap_w[0] = sample;

  for (genvar i = 0; i < WINDOW; i++) begin : g_tap
    dmsd_tap #(
      .SAMPLE_BITS(SAMPLE_BITS)
    ) u_tap (
      .clk     (clk),
      .rst_n   (rst_n),
      .shift_en(feed),
      .d       (tap_w[i]),
      .q       (tap_w[i+1])
    );
  end

  // last cell holds the sample that leaves the window
  assign sum_nxt = sum_r + SUM_W'(sample) - SUM_W'(tap_w[WINDOW]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
    end else if (feed) begin
      sum_r <= sum_nxt;
    end
  end

  assign sum = sum_r;

endmodule

// ===== rtl/dmsd_div_cell.sv =====
// Divide-by-WINDOW stage of one axis: |sum| times a reciprocal, sign restored,
// truncating toward zero; average and magnitude registered. Depends on nothing.
module dmsd_div_cell #(
  parameter int WINDOW      = 8,
  parameter int SAMPLE_BITS = 16,
  localparam int SUM_W      = SAMPLE_BITS + $clog2(WINDOW)
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [SUM_W-1:0]       sum,
  output logic signed [SAMPLE_BITS-1:0] avg,
  output logic [SAMPLE_BITS-1:0]        mag
);

  localparam int SHIFT  = SUM_W + $clog2(WINDOW);
  localparam int PROD_W = 2 * SUM_W + 1;
  // ceil(2^SHIFT / WINDOW): exact quotient for any SUM_W-bit dividend
  localparam logic [SUM_W:0] RECIP =
    (SUM_W+1)'(((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

  logic                          neg;
  logic [SUM_W-1:0]              abs_sum;
  logic [PROD_W-1:0]             prod;
  logic [SAMPLE_BITS-1:0]        quo;
  logic signed [SAMPLE_BITS-1:0] avg_r;
  logic [SAMPLE_BITS-1:0]        mag_r;

  assign neg     = sum[SUM_W-1];
  assign abs_sum = neg ? SUM_W'(-sum) : SUM_W'(sum);
  assign prod    = PROD_W'(abs_sum) * PROD_W'(RECIP);
  assign quo     = prod[SHIFT +: SAMPLE_BITS];

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r <= quo;
      avg_r <= neg ? -quo : quo;
    end
  end

  assign avg = avg_r;
  assign mag = mag_r;

endmodule

// ===== rtl/door_magnet_state_detector_core.sv =====
// Door magnet state detector, top level: axis filters, divide stage,
// change tracking and the door state machine.
// Depends on dmsd_pkg, dmsd_axis, dmsd_tap and dmsd_div_cell.
//
// Usage:
//   in_*  : one three-axis magnetometer sample per beat, a valid flag per axis.
//           An axis whose flag is low leaves its moving average untouched.
//   out_* : one result beat per input beat, in order: door state, changed flag
//           and the three filtered values.
//   cfg_* : threshold writes, taken at any edge with cfg_wen high; write only
//           while no beat is in flight.
// Pipeline: the history and running sum update at the accepting edge, then the
// averages from a reciprocal multiply are registered, then the result. Throughput:
// one beat per cycle while the receiver does not stall.
// Reset (rst_n low, synchronous) zeroes the history, sums and reported values,
// sets the door state to unknown and loads the threshold defaults (200, 400, 10).
// When the receiver stalls, the whole pipeline holds; in_tready follows
// out_tready while a result waits, and is high whenever the output register is
// empty.
module door_magnet_state_detector_core #(
  parameter int WINDOW      = 8,
  parameter int SAMPLE_BITS = 16,
  localparam int IN_W       = ((3 * (SAMPLE_BITS + 1) + 7) / 8) * 8,
  localparam int OUT_W      = ((4 + 3 * SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // x_valid, sample_x, y_valid, sample_y, z_valid, sample_z
  input  logic [IN_W-1:0]                 in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // door_state, changed, filtered_x, filtered_y, filtered_z
  output logic [OUT_W-1:0]                out_tdata,
  input  logic                            cfg_wen,
  input  logic [dmsd_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [dmsd_pkg::CFG_W-1:0]      cfg_wdata
);

  localparam int SB     = SAMPLE_BITS;
  localparam int AXES   = dmsd_pkg::AXES;
  localparam int SUM_W  = SB + $clog2(WINDOW);
  localparam int CMP_W  = (SB > dmsd_pkg::CFG_W) ? SB : dmsd_pkg::CFG_W;
  localparam int DIFF_W = (SB + 1 > dmsd_pkg::CFG_W) ? SB + 1 : dmsd_pkg::CFG_W;
  localparam int FLD_W  = SB + 1;

  logic en;
  logic in_acc;

  logic [dmsd_pkg::CFG_W-1:0] open_thr_r;
  logic [dmsd_pkg::CFG_W-1:0] close_thr_r;
  logic [dmsd_pkg::CFG_W-1:0] delta_thr_r;

  logic signed [SUM_W-1:0] sum_w [AXES];
  logic                    sv_r;

  logic                  avg_v_r;
  logic signed [SB-1:0]  avg_w [AXES];
  logic [SB-1:0]         mag_w [AXES];
  logic signed [SB-1:0]  rep_r [AXES];
  logic [AXES-1:0]       hit;

  dmsd_pkg::door_state_t door_r;
  dmsd_pkg::door_state_t door_nxt;
  logic [dmsd_pkg::CODE_W-1:0] code_nxt;
  logic                  over_open;
  logic                  over_close;

  logic             out_valid_r;
  logic [OUT_W-1:0] out_data_r;
  logic [OUT_W-1:0] out_nxt;

  // whole pipeline advances together when the output register can take a beat
  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;
  assign in_acc    = in_tvalid && en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_thr_r  <= dmsd_pkg::OPEN_THR_RST;
      close_thr_r <= dmsd_pkg::CLOSE_THR_RST;
      delta_thr_r <= dmsd_pkg::DELTA_THR_RST;
    end else if (cfg_wen) begin
      case (cfg_addr)
        dmsd_pkg::REG_OPEN_THR:  open_thr_r  <= cfg_wdata;
        dmsd_pkg::REG_CLOSE_THR: close_thr_r <= cfg_wdata;
        dmsd_pkg::REG_DELTA_THR: delta_thr_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  for (genvar a = 0; a < AXES; a++) begin : g_axis
    dmsd_axis #(
      .WINDOW     (WINDOW),
      .SAMPLE_BITS(SB)
    ) u_axis (
      .clk   (clk),
      .rst_n (rst_n),
      .feed  (in_acc && in_tdata[a*FLD_W]),
      .sample(in_tdata[a*FLD_W+1 +: SB]),
      .sum   (sum_w[a])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sv_r <= 1'b0;
    end else if (en) begin
      sv_r <= in_tvalid;
    end
  end

  // divide |sum| by WINDOW, sign restored afterwards: truncates toward zero
  for (genvar a = 0; a < AXES; a++) begin : g_div
    dmsd_div_cell #(
      .WINDOW     (WINDOW),
      .SAMPLE_BITS(SB)
    ) u_div (
      .clk(clk),
      .en (en),
      .sum(sum_w[a]),
      .avg(avg_w[a]),
      .mag(mag_w[a])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      avg_v_r <= 1'b0;
    end else if (en) begin
      avg_v_r <= sv_r;
    end
  end

  always_comb begin
    logic signed [SB:0] diff;
    logic [SB:0]        adiff;
    for (int a = 0; a < AXES; a++) begin
      diff   = (SB+1)'(rep_r[a]) - (SB+1)'(avg_w[a]);
      adiff  = diff[SB] ? (SB+1)'(-diff) : (SB+1)'(diff);
      hit[a] = DIFF_W'(adiff) >= DIFF_W'(delta_thr_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < AXES; a++) begin
        rep_r[a] <= '0;
      end
    end else if (en && avg_v_r) begin
      for (int a = 0; a < AXES; a++) begin
        if (hit[a]) begin
          rep_r[a] <= avg_w[a];
        end
      end
    end
  end

  always_comb begin
    over_open  = 1'b0;
    over_close = 1'b0;
    for (int a = 0; a < AXES; a++) begin
      over_open  = over_open  || (CMP_W'(mag_w[a]) > CMP_W'(open_thr_r));
      over_close = over_close || (CMP_W'(mag_w[a]) > CMP_W'(close_thr_r));
    end
  end

  always_comb begin
    door_nxt = door_r;
    case (door_r)
      dmsd_pkg::DOOR_OPEN: begin
        if (over_open) door_nxt = dmsd_pkg::DOOR_CLOSING;
      end
      dmsd_pkg::DOOR_CLOSING: begin
        if (over_close) door_nxt = dmsd_pkg::DOOR_CLOSED;
      end
      dmsd_pkg::DOOR_CLOSED: begin
        if (!over_close) door_nxt = dmsd_pkg::DOOR_OPENING;
      end
      dmsd_pkg::DOOR_OPENING: begin
        if (!over_open) door_nxt = dmsd_pkg::DOOR_OPEN;
      end
      default: begin
        door_nxt = over_open ? dmsd_pkg::DOOR_CLOSED : dmsd_pkg::DOOR_OPEN;
      end
    endcase
  end

  always_comb begin
    case (door_nxt)
      dmsd_pkg::DOOR_OPEN:    code_nxt = dmsd_pkg::CODE_OPEN;
      dmsd_pkg::DOOR_CLOSING: code_nxt = dmsd_pkg::CODE_CLOSING;
      dmsd_pkg::DOOR_CLOSED:  code_nxt = dmsd_pkg::CODE_CLOSED;
      dmsd_pkg::DOOR_OPENING: code_nxt = dmsd_pkg::CODE_OPENING;
      default:                code_nxt = dmsd_pkg::CODE_UNKNOWN;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      door_r <= dmsd_pkg::DOOR_UNKNOWN;
    end else if (en && avg_v_r) begin
      door_r <= door_nxt;
    end
  end

  always_comb begin
    out_nxt      = '0;
    out_nxt[2:0] = code_nxt;
    out_nxt[3]   = |hit;
    for (int a = 0; a < AXES; a++) begin
      out_nxt[4 + a*SB +: SB] = avg_w[a];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= avg_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en && avg_v_r) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_hold_sum_no_feed: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !in_tdata[0]) |=> $stable(sum_w[0]))
    else $error("x sum moved without a valid x sample");

  a_open_succ: assert property (@(posedge clk) disable iff (!rst_n)
    (door_r == dmsd_pkg::DOOR_OPEN) |=>
      (door_r == dmsd_pkg::DOOR_OPEN || door_r == dmsd_pkg::DOOR_CLOSING))
    else $error("open state left to an illegal successor");

  a_closing_succ: assert property (@(posedge clk) disable iff (!rst_n)
    (door_r == dmsd_pkg::DOOR_CLOSING) |=>
      (door_r == dmsd_pkg::DOOR_CLOSING || door_r == dmsd_pkg::DOOR_CLOSED))
    else $error("closing state left to an illegal successor");

  a_state_only_on_beat: assert property (@(posedge clk) disable iff (!rst_n)
    !(en && avg_v_r) |=> $stable(door_r))
    else $error("door state moved without a filtered beat");

endmodule

// ===== tb/door_magnet_state_detector_checker.sv =====
// Result checker for door_magnet_state_detector_core: watches the in/out streams and
// the threshold port, predicts every result beat and compares it field by field.
// Depends on dmsd_pkg.
module door_magnet_state_detector_checker #(
  parameter int WINDOW = 8,
  parameter int IN_W   = 56,
  parameter int OUT_W  = 56
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [IN_W-1:0]                 in_tdata,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [OUT_W-1:0]                out_tdata,
  input  logic                            cfg_wen,
  input  logic [dmsd_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [dmsd_pkg::CFG_W-1:0]      cfg_wdata,
  output int                              mismatches,
  output int                              outstanding,
  output int                              reports_checked,
  output int                              changes_seen,
  output logic [7:0]                      states_seen
);

  localparam int SLOT_W = $clog2(WINDOW);

  typedef struct {
    logic [dmsd_pkg::CODE_W-1:0] door;
    logic                        changed;
    logic signed [15:0]          fx;
    logic signed [15:0]          fy;
    logic signed [15:0]          fz;
  } door_report_t;

  logic signed [15:0]          ring [3][WINDOW];
  logic signed [18:0]          ring_sum [3];
  logic [SLOT_W-1:0]           ring_slot [3];
  logic signed [15:0]          last_reported [3];
  logic [dmsd_pkg::CODE_W-1:0] door_code;
  logic [dmsd_pkg::CFG_W-1:0]  open_thr, close_thr, delta_thr;

  door_report_t                pending_reports [$];
  door_report_t                want;
  logic [dmsd_pkg::CODE_W-1:0] got_door;

  function automatic door_report_t predict_door_report(input logic [IN_W-1:0] beat);
    door_report_t       rpt;
    logic [2:0]         valid;
    logic signed [15:0] raw [3];
    logic signed [15:0] avg [3];
    int                 a, diff, mag;
    logic               over_open, over_close;
    valid = {beat[34], beat[17], beat[0]};
    raw[0] = beat[16:1];
    raw[1] = beat[33:18];
    raw[2] = beat[50:35];
    rpt.changed = 1'b0;
    over_open = 1'b0;
    over_close = 1'b0;
    for (a = 0; a < 3; a++) begin
      if (valid[a]) begin
        ring_sum[a] = ring_sum[a] - ring[a][ring_slot[a]] + raw[a];
        ring[a][ring_slot[a]] = raw[a];
        ring_slot[a] = (ring_slot[a] == SLOT_W'(WINDOW - 1)) ? '0 : ring_slot[a] + 1'b1;
      end
      avg[a] = 16'(int'(ring_sum[a]) / WINDOW);
      diff = int'(last_reported[a]) - int'(avg[a]);
      if (diff < 0) diff = -diff;
      if (diff >= int'(delta_thr)) begin
        last_reported[a] = avg[a];
        rpt.changed = 1'b1;
      end
      mag = (avg[a] < 0) ? -int'(avg[a]) : int'(avg[a]);
      if (mag > int'(open_thr)) over_open = 1'b1;
      if (mag > int'(close_thr)) over_close = 1'b1;
    end
    case (door_code)
      dmsd_pkg::CODE_OPEN:    if (over_open) door_code = dmsd_pkg::CODE_CLOSING;
      dmsd_pkg::CODE_CLOSING: if (over_close) door_code = dmsd_pkg::CODE_CLOSED;
      dmsd_pkg::CODE_CLOSED:  if (!over_close) door_code = dmsd_pkg::CODE_OPENING;
      dmsd_pkg::CODE_OPENING: if (!over_open) door_code = dmsd_pkg::CODE_OPEN;
      default: door_code = over_open ? dmsd_pkg::CODE_CLOSED : dmsd_pkg::CODE_OPEN;
    endcase
    rpt.door = door_code;
    rpt.fx = avg[0];
    rpt.fy = avg[1];
    rpt.fz = avg[2];
    return rpt;
  endfunction

  task automatic compare_field(input string field, input int expected_val, input int actual_val);
    if (expected_val != actual_val) begin
      if (mismatches < 10)
        $display("Mismatch on result beat %0d, %s: expected %0d, got %0d",
                 reports_checked, field, expected_val, actual_val);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int a = 0; a < 3; a++) begin
        for (int s = 0; s < WINDOW; s++) ring[a][s] = '0;
        ring_sum[a] = '0;
        ring_slot[a] = '0;
        last_reported[a] = '0;
      end
      door_code = dmsd_pkg::CODE_UNKNOWN;
      open_thr = dmsd_pkg::OPEN_THR_RST;
      close_thr = dmsd_pkg::CLOSE_THR_RST;
      delta_thr = dmsd_pkg::DELTA_THR_RST;
      pending_reports.delete();
      states_seen = '0;
    end else begin
      if (cfg_wen) begin
        case (cfg_addr)
          dmsd_pkg::REG_OPEN_THR:  open_thr = cfg_wdata;
          dmsd_pkg::REG_CLOSE_THR: close_thr = cfg_wdata;
          dmsd_pkg::REG_DELTA_THR: delta_thr = cfg_wdata;
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        got_door = out_tdata[2:0];
        states_seen[got_door] = 1'b1;
        if (out_tdata[3]) changes_seen++;
        if (pending_reports.size() == 0) begin
          if (mismatches < 10)
            $display("Result beat %0d arrived with nothing expected: %h",
                     reports_checked, out_tdata);
          mismatches++;
        end else begin
          want = pending_reports.pop_front();
          compare_field("door_state", int'(want.door), int'(got_door));
          compare_field("changed", int'(want.changed), int'(out_tdata[3]));
          compare_field("filtered_x", int'(want.fx), int'($signed(out_tdata[19:4])));
          compare_field("filtered_y", int'(want.fy), int'($signed(out_tdata[35:20])));
          compare_field("filtered_z", int'(want.fz), int'($signed(out_tdata[51:36])));
        end
        reports_checked++;
      end
      if (in_tvalid && in_tready)
        pending_reports.push_back(predict_door_report(in_tdata));
    end
    outstanding <= pending_reports.size();
  end

endmodule

// ===== tb/testbench.sv =====
// Top of the door_magnet_state_detector_core testbench: clock, reset, threshold phases,
// directed and random sample beats, receiver stalls, watchdog and verdict.
// Depends on dmsd_pkg, the core and door_magnet_state_detector_checker.
module testbench;

  localparam int IN_W            = 56;
  localparam int OUT_W           = 56;
  localparam int LATENCY         = 2;
  localparam int DRAIN_CYCLES    = 2 * LATENCY;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int STALL_LIMIT     = 5000;
  localparam int RANDOM_PHASES   = 10;
  localparam int BEATS_PER_PHASE = 183;

  localparam int LEVEL_QUIET   = 0;
  localparam int LEVEL_MID     = 1;
  localparam int LEVEL_STRONG  = 2;
  localparam int LEVEL_EXTREME = 3;

  localparam int SINK_ALWAYS   = 0;
  localparam int SINK_COIN     = 1;
  localparam int SINK_PERIODIC = 2;
  localparam int SINK_MOSTLY   = 3;

  logic                            clk;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [IN_W-1:0]                 in_tdata;
  logic                            out_tvalid;
  logic                            out_tready;
  logic [OUT_W-1:0]                out_tdata;
  logic                            cfg_wen;
  logic [dmsd_pkg::CFG_ADDR_W-1:0] cfg_addr;
  logic [dmsd_pkg::CFG_W-1:0]      cfg_wdata;

  int                    mismatches;
  int                    outstanding;
  int                    reports_checked;
  int                    changes_seen;
  logic [7:0]            states_seen;

  int                    burst_left;
  int                    settings_used;
  int                    holdoffs_done;
  logic [15:0]           open_now;
  logic [15:0]           close_now;

  door_magnet_state_detector_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // x_valid, sample_x, y_valid, sample_y, z_valid, sample_z
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // door_state, changed, filtered_x, filtered_y, filtered_z
    .cfg_wen    (cfg_wen),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  door_magnet_state_detector_checker #(
    .IN_W  (IN_W),
    .OUT_W (OUT_W)
  ) u_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .cfg_wen         (cfg_wen),
    .cfg_addr        (cfg_addr),
    .cfg_wdata       (cfg_wdata),
    .mismatches      (mismatches),
    .outstanding     (outstanding),
    .reports_checked (reports_checked),
    .changes_seen    (changes_seen),
    .states_seen     (states_seen)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [IN_W-1:0] pack_sample(
    input logic xv, input logic [15:0] sx,
    input logic yv, input logic [15:0] sy,
    input logic zv, input logic [15:0] sz
  );
    return {{(IN_W - 51){1'b0}}, sz, zv, sy, yv, sx, xv};
  endfunction

  // Signed level whose magnitude sits in the band named by kind.
  function automatic int pick_level(input int kind);
    int lo, hi, mag;
    case (kind)
      LEVEL_QUIET: begin
        lo = 0;
        hi = int'(open_now) / 2;
      end
      LEVEL_MID: begin
        lo = int'(open_now) + 1;
        hi = (close_now > open_now) ? int'(close_now) : int'(open_now) + 400;
      end
      LEVEL_STRONG: begin
        lo = int'(close_now) + 1;
        hi = int'(close_now) + 2000;
      end
      default: begin
        lo = 32767;
        hi = 32768;
      end
    endcase
    if (hi > 32768) hi = 32768;
    if (lo > hi) lo = hi;
    mag = int'($urandom_range(hi, lo));
    return $urandom_range(0, 1) ? mag : -mag;
  endfunction

  task automatic send_sample(input logic [IN_W-1:0] beat);
    int gap;
    if (burst_left == 0) begin
      burst_left = int'($urandom_range(1, 48));
      gap = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(1, 7));
      if (gap != 0) begin
        @(negedge clk);
        in_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata  <= beat;
    do @(posedge clk); while (!in_tready);
    burst_left--;
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_thresholds(input logic [15:0] open_v, input logic [15:0] close_v,
                                  input logic [15:0] delta_v);
    @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_addr  <= dmsd_pkg::REG_OPEN_THR;
    cfg_wdata <= open_v;
    @(negedge clk);
    cfg_addr  <= dmsd_pkg::REG_CLOSE_THR;
    cfg_wdata <= close_v;
    @(negedge clk);
    cfg_addr  <= dmsd_pkg::REG_DELTA_THR;
    cfg_wdata <= delta_v;
    @(negedge clk);
    cfg_wen   <= 1'b0;
    open_now = open_v;
    close_now = close_v;
    settings_used++;
  endtask

  // Runs of beats around a common per-axis level, mixed with pure noise runs.
  task automatic random_stretch(input int count);
    int          kind, len, span, a, val;
    int          level [3];
    logic [2:0]  valid;
    logic [15:0] smp [3];
    while (count > 0) begin
      kind = $urandom_range(0, 9);
      len = $urandom_range(4, 24);
      if (len > count) len = count;
      span = $urandom_range(0, 40);
      for (a = 0; a < 3; a++) begin
        if (kind < 6) level[a] = pick_level(kind / 2);
        else if (kind == 6) level[a] = pick_level(a == 0 ? LEVEL_STRONG : LEVEL_QUIET);
        else level[a] = pick_level(LEVEL_EXTREME);
      end
      repeat (len) begin
        for (a = 0; a < 3; a++) begin
          if (kind >= 8) begin
            valid[a] = 1'($urandom_range(0, 1));
            smp[a] = 16'($urandom);
          end else begin
            valid[a] = ($urandom_range(0, 7) != 0);
            val = level[a] + int'($urandom_range(0, 2 * span)) - span;
            if (val > 32767) val = 32767;
            if (val < -32768) val = -32768;
            smp[a] = val[15:0];
          end
        end
        send_sample(pack_sample(valid[0], smp[0], valid[1], smp[1], valid[2], smp[2]));
      end
      count -= len;
    end
  endtask

  initial begin : result_sink
    int mode, span, tick;
    out_tready = 1'b0;
    holdoffs_done = 0;
    tick = 0;
    wait (rst_n === 1'b1);
    forever begin
      mode = $urandom_range(SINK_ALWAYS, SINK_MOSTLY);
      span = $urandom_range(8, 160);
      // one long hold-off while beats are still coming, to back the pipe up
      if (holdoffs_done == 0 && reports_checked >= 500 && in_tvalid) begin
        @(negedge clk);
        out_tready <= 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
        holdoffs_done++;
      end
      repeat (span) begin
        @(negedge clk);
        tick++;
        case (mode)
          SINK_ALWAYS:   out_tready <= 1'b1;
          SINK_COIN:     out_tready <= 1'($urandom_range(0, 1));
          SINK_PERIODIC: out_tready <= (tick % 5) < 3;
          default:       out_tready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wen) quiet = 0;
      else quiet++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : stimulus
    int          p;
    logic [15:0] base;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_wen = 1'b0;
    cfg_addr = dmsd_pkg::REG_OPEN_THR;
    cfg_wdata = '0;
    burst_left = 0;
    settings_used = 1;
    open_now = dmsd_pkg::OPEN_THR_RST;
    close_now = dmsd_pkg::CLOSE_THR_RST;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: no valid axis, full-scale negative ramp, single valid axis, decay to zero
    send_sample(pack_sample(1'b0, 16'h8000, 1'b0, 16'h7fff, 1'b0, 16'h1234));
    repeat (8) send_sample(pack_sample(1'b1, 16'h8000, 1'b1, 16'h8000, 1'b1, 16'h8000));
    send_sample(pack_sample(1'b1, 16'h7fff, 1'b0, 16'hffff, 1'b0, 16'h7fff));
    repeat (8) send_sample(pack_sample(1'b1, 16'h0000, 1'b1, 16'h0000, 1'b1, 16'h0000));
    send_sample(pack_sample(1'b1, 16'h7fff, 1'b1, 16'h5555, 1'b1, 16'haaaa));
    send_sample(pack_sample(1'b1, 16'h7fff, 1'b1, 16'haaaa, 1'b1, 16'h5555));
    send_sample(pack_sample(1'b0, 16'hffff, 1'b0, 16'hffff, 1'b0, 16'hffff));
    drain_results();

    for (p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: write_thresholds(16'd0, 16'd0, 16'd0);
        1: write_thresholds(16'hffff, 16'hffff, 16'hffff);
        2: write_thresholds(16'd32767, 16'd32768, 16'd1);
        3: write_thresholds(dmsd_pkg::OPEN_THR_RST, dmsd_pkg::CLOSE_THR_RST,
                            dmsd_pkg::DELTA_THR_RST);
        4: write_thresholds(16'($urandom_range(500, 3000)), 16'($urandom_range(0, 400)),
                            16'($urandom_range(0, 50)));
        default: begin
          base = 16'($urandom_range(0, 3000));
          write_thresholds(base, base + 16'($urandom_range(0, 3000)),
                           16'($urandom_range(0, 300)));
        end
      endcase
      random_stretch(BEATS_PER_PHASE);
      drain_results();
    end

    $display("Checked %0d result beats over %0d threshold settings, %0d with changed set.",
             reports_checked, settings_used, changes_seen);
    $display("Door codes seen (one bit per code): %b; long output hold-offs: %0d.",
             states_seen, holdoffs_done);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
